// ----- hdl/lcd_nibble_queue_driver_defines.svh -----
// ---------------------------------------------------------------------------
// LCD nibble queue driver: assertion macros
// Shared concurrent-assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LCD_NIBBLE_QUEUE_DRIVER_DEFINES_SVH
`define LCD_NIBBLE_QUEUE_DRIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lnq check failed");

// The consequent must hold in the cycle after the antecedent.
`define LNQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lnq check failed");

`endif

// ----- hdl/lnq_pkg.sv -----
// ---------------------------------------------------------------------------
// LCD nibble queue driver package
// Types, result codes and the microcode table of the step sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package lnq_pkg;

   localparam int LNQ_QUEUE_DEPTH = 64;

   // Result kinds on the response channel.
   localparam logic [1:0] RK_ACK   = 2'd0;
   localparam logic [1:0] RK_WRITE = 2'd1;
   localparam logic [1:0] RK_IDLE  = 2'd2;

   // Input kinds on the request channel.
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Steps that fall through with J_NEXT must keep consecutive values.
   typedef enum logic [3:0] {
      S_IDLE    = 4'd0,
      S_PUSH    = 4'd1,
      S_EMPTY   = 4'd2,
      S_HEAD    = 4'd3,
      S_POP     = 4'd4,
      S_HI_E    = 4'd5,
      S_HI_L    = 4'd6,
      S_LO_E    = 4'd7,
      S_LO_L    = 4'd8,
      S_ESC     = 4'd9,
      S_SKIP    = 4'd10,
      S_WAIT    = 4'd11,
      S_RELATCH = 4'd12,
      S_LONE    = 4'd13
   } step_type;

   typedef enum logic [2:0] {
      J_NEXT,
      J_GOTO,
      J_ZERO,
      J_SHORT,
      J_DISPATCH
   } jump_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ACK,
      EMIT_WRITE,
      EMIT_IDLE
   } emit_type;

   typedef enum logic [1:0] {
      BUSY_KEEP,
      BUSY_SET,
      BUSY_CLR
   } busy_op_type;

   typedef struct packed {
      step_type    target;
      jump_type    jump;
      emit_type    emit;
      logic        wait_req;
      logic        enable;
      logic        nib_hi;
      logic        last;
      logic        do_push;
      busy_op_type busy_op;
      logic        latch;
      logic        rs_set;
      logic        rs_clr;
      logic        pop;
   } ucode_type;

   // Queue conditions that steer conditional jumps.
   typedef struct packed {
      logic empty;
      logic short_q;
      logic head_zero;
   } status_type;

   // One result item as built by the datapath.
   typedef struct packed {
      logic [1:0] result_kind;
      logic       reg_select;
      logic       enable_line;
      logic [3:0] nibble_out;
      logic       push_accepted;
      logic       busy_flag;
      logic       last;
   } result_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      w.target  = S_IDLE;
      w.jump    = J_NEXT;
      w.emit    = EMIT_NONE;
      w.busy_op = BUSY_KEEP;
      unique case (step)
         S_IDLE: begin
            w.wait_req = 1'b1;
            w.jump     = J_DISPATCH;
         end
         S_PUSH: begin
            w.emit    = EMIT_ACK;
            w.do_push = 1'b1;
            w.busy_op = BUSY_SET;
            w.last    = 1'b1;
            w.jump    = J_GOTO;
         end
         S_EMPTY: begin
            w.emit    = EMIT_IDLE;
            w.busy_op = BUSY_CLR;
            w.last    = 1'b1;
            w.jump    = J_GOTO;
         end
         S_HEAD: begin
            w.latch  = 1'b1;
            w.rs_set = 1'b1;
            w.jump   = J_ZERO;
            w.target = S_ESC;
         end
         S_POP: begin
            w.pop = 1'b1;
         end
         S_HI_E: begin
            w.emit   = EMIT_WRITE;
            w.enable = 1'b1;
            w.nib_hi = 1'b1;
         end
         S_HI_L: begin
            w.emit   = EMIT_WRITE;
            w.nib_hi = 1'b1;
         end
         S_LO_E: begin
            w.emit   = EMIT_WRITE;
            w.enable = 1'b1;
         end
         S_LO_L: begin
            w.emit = EMIT_WRITE;
            w.last = 1'b1;
            w.jump = J_GOTO;
         end
         S_ESC: begin
            w.jump   = J_SHORT;
            w.target = S_LONE;
         end
         S_LONE: begin
            w.emit = EMIT_IDLE;
            w.last = 1'b1;
            w.jump = J_GOTO;
         end
         S_SKIP: begin
            w.pop    = 1'b1;
            w.rs_clr = 1'b1;
         end
         S_WAIT: begin
            w.jump = J_NEXT;
         end
         S_RELATCH: begin
            w.latch  = 1'b1;
            w.jump   = J_GOTO;
            w.target = S_POP;
         end
         default: begin
            w.jump = J_GOTO;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lnq_sequencer.sv -----
// ---------------------------------------------------------------------------
// LCD nibble queue driver: step sequencer
// Step counter over the microcode table, with conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module lnq_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_kind,
   input  wire logic                out_free,
   input  wire lnq_pkg::status_type status,
   output lnq_pkg::ucode_type       word,
   output logic                     fire
);

   lnq_pkg::step_type pc_ff;
   lnq_pkg::step_type pc_in;

   assign word = lnq_pkg::ucode_rom(pc_ff);

   // A step fires once its wait condition is met; until then nothing moves.
   always_comb begin
      if (word.wait_req) begin
         fire = req_valid;
      end else if (word.emit != lnq_pkg::EMIT_NONE) begin
         fire = out_free;
      end else begin
         fire = 1'b1;
      end
   end

   always_comb begin
      pc_in = pc_ff;
      if (fire) begin
         unique case (word.jump)
            lnq_pkg::J_NEXT:  pc_in = lnq_pkg::step_type'(pc_ff + 4'd1);
            lnq_pkg::J_GOTO:  pc_in = word.target;
            lnq_pkg::J_ZERO:  pc_in = status.head_zero ? word.target
                                      : lnq_pkg::step_type'(pc_ff + 4'd1);
            lnq_pkg::J_SHORT: pc_in = status.short_q ? word.target
                                      : lnq_pkg::step_type'(pc_ff + 4'd1);
            lnq_pkg::J_DISPATCH: begin
               if (req_kind == lnq_pkg::KIND_PUSH) begin
                  pc_in = lnq_pkg::S_PUSH;
               end else if (status.empty) begin
                  pc_in = lnq_pkg::S_EMPTY;
               end else begin
                  pc_in = lnq_pkg::S_HEAD;
               end
            end
            default: pc_in = lnq_pkg::S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= lnq_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lnq_queue.sv -----
// ---------------------------------------------------------------------------
// LCD nibble queue driver: queue datapath
// Byte ring memory, indices, fill count, busy flag and result assembly.
// ---------------------------------------------------------------------------
`default_nettype none

`include "lcd_nibble_queue_driver_defines.svh"

module lnq_queue #(
   parameter int QUEUE_DEPTH = lnq_pkg::LNQ_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         req_byte,
   input  wire lnq_pkg::ucode_type word,
   input  wire logic               fire,
   output lnq_pkg::status_type     status,
   output lnq_pkg::result_type     result
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

   logic [7:0]    mem [QUEUE_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] count_ff, count_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic [7:0]    byte_ff, byte_in;
   logic          rs_ff, rs_in;
   logic          busy_ff, busy_in;
   logic          full;
   logic          do_write;
   logic          do_pop;

   assign full     = (count_ff == LAST_SLOT);
   assign do_write = fire && word.do_push && !full;
   assign do_pop   = fire && word.pop;

   assign status.empty     = (count_ff == '0);
   assign status.short_q   = (count_ff < AW'(2));
   assign status.head_zero = (rd_data_ff == 8'h00);

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      in_byte_in = in_byte_ff;
      byte_in    = byte_ff;
      rs_in      = rs_ff;
      busy_in    = busy_ff;
      if (fire && word.wait_req) begin
         in_byte_in = req_byte;
      end
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
         count_in  = count_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + AW'(1);
         count_in  = count_ff - AW'(1);
      end
      if (fire && word.latch) begin
         byte_in = rd_data_ff;
      end
      if (fire && word.rs_set) begin
         rs_in = 1'b1;
      end else if (fire && word.rs_clr) begin
         rs_in = 1'b0;
      end
      if (fire) begin
         unique case (word.busy_op)
            lnq_pkg::BUSY_SET: busy_in = 1'b1;
            lnq_pkg::BUSY_CLR: busy_in = 1'b0;
            default:           busy_in = busy_ff;
         endcase
      end
   end

   // Fields that do not belong to the emitted kind stay at zero.
   always_comb begin
      result           = '0;
      result.busy_flag = busy_in;
      result.last      = word.last;
      unique case (word.emit)
         lnq_pkg::EMIT_ACK: begin
            result.result_kind   = lnq_pkg::RK_ACK;
            result.push_accepted = !full;
         end
         lnq_pkg::EMIT_WRITE: begin
            result.result_kind = lnq_pkg::RK_WRITE;
            result.reg_select  = rs_ff;
            result.enable_line = word.enable;
            result.nibble_out  = word.nib_hi ? byte_ff[7:4] : byte_ff[3:0];
         end
         lnq_pkg::EMIT_IDLE: begin
            result.result_kind = lnq_pkg::RK_IDLE;
         end
         default: begin
            result.result_kind = lnq_pkg::RK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= in_byte_ff;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         busy_ff   <= 1'b0;
         rs_ff     <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         busy_ff   <= busy_in;
         rs_ff     <= rs_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      byte_ff    <= byte_in;
   end

   `LNQ_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= LAST_SLOT)
   `LNQ_ASSERT_SAME(a_pop_nonempty, do_pop, count_ff != '0)
   `LNQ_ASSERT_NEXT(a_full_push_holds, fire && word.do_push && full, $stable(wr_ptr_ff))

endmodule

`default_nettype wire

// ----- hdl/lcd_nibble_queue_driver.sv -----
// ---------------------------------------------------------------------------
// LCD nibble queue driver
// Byte queue feeding a 4-bit character LCD bus, run by a microcoded sequencer.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_*     in         push of one byte or a tick that sends the next entry
//   rsp_*     out        push ack, LCD port write or idle report; tlast ends a run
//
// The step sequencer handles one transaction at a time, and the registered
// memory read sets the extra steps of a data entry and an escaped command.
// Reset clears indices, fill count, busy flag and sequencer; the byte store
// needs no clearing. A stalled response holds the sequencer at its step.
//
`default_nettype none

module lcd_nibble_queue_driver #(
   parameter int QUEUE_DEPTH = lnq_pkg::LNQ_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] byte_value
   input  wire logic       req_tuser,   // [0] kind
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [0] reg_select, [1] enable_line,
                                        // [5:2] nibble_out, [6] push_accepted,
                                        // [7] busy_flag
   output logic [1:0]      rsp_tuser,   // [1:0] result_kind
   output logic            rsp_tlast
);

   lnq_pkg::ucode_type  word;
   lnq_pkg::status_type status;
   lnq_pkg::result_type result;
   logic                fire;
   logic                out_free;
   logic                load;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;
   logic       rsp_last_ff, rsp_last_in;

   lnq_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .out_free  (out_free),
      .status    (status),
      .word      (word),
      .fire      (fire)
   );

   lnq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .req_byte (req_tdata),
      .word     (word),
      .fire     (fire),
      .status   (status),
      .result   (result)
   );

   assign req_tready = word.wait_req;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = fire && (word.emit != lnq_pkg::EMIT_NONE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {result.busy_flag, result.push_accepted, result.nibble_out,
                         result.enable_line, result.reg_select};
         rsp_user_in  = result.result_kind;
         rsp_last_in  = result.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
